### hw/rtl/irpwd_pkg.sv
// Shared constants, types and window helpers for the infrared pulse-width frame decoder.
// No dependencies; imported by every module of the decoder.
package irpwd_pkg;

    localparam int CODE_BITS_DEF = 12;
    localparam int DUR_W         = 16;
    localparam int CODE_W        = 12;
    localparam int TOL_W         = 7;
    localparam int EXC_W         = 10;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int NOM_W         = 13;
    localparam int PCT_W         = 8;
    localparam int BOUND_W       = 21;
    localparam int SCALED_W      = 23;
    localparam int IN_TDATA_W    = ((DUR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((CODE_W + 7) / 8) * 8;

    localparam logic [NOM_W-1:0] HDR_MARK_US   = 13'd4000;
    localparam logic [NOM_W-1:0] HDR_SPACE_US  = 13'd4000;
    localparam logic [NOM_W-1:0] BIT_MARK_US   = 13'd500;
    localparam logic [NOM_W-1:0] ONE_SPACE_US  = 13'd2000;
    localparam logic [NOM_W-1:0] ZERO_SPACE_US = 13'd1000;

    localparam logic [PCT_W-1:0] PCT_FULL = 8'd100;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_EXCESS = 8'd1;

    localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;
    localparam logic [EXC_W-1:0] EXC_RESET = 10'd100;

    typedef struct packed {
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
    } t_window;

    typedef struct packed {
        t_window hdr_mark;
        t_window hdr_space;
        t_window bit_mark;
        t_window one_space;
        t_window zero_space;
    } t_bounds;

    typedef struct packed {
        logic hdr_mark;
        logic hdr_space;
        logic bit_mark;
        logic one_space;
        logic zero_space;
    } t_match;

    function automatic logic [NOM_W-1:0] mark_nominal(input logic [NOM_W-1:0] nom,
                                                      input logic [EXC_W-1:0] excess);
        return nom + NOM_W'(excess);
    endfunction

    function automatic logic [NOM_W-1:0] space_nominal(input logic [NOM_W-1:0] nom,
                                                       input logic [EXC_W-1:0] excess);
        return (nom > NOM_W'(excess)) ? (nom - NOM_W'(excess)) : '0;
    endfunction

    function automatic t_window window_of(input logic [NOM_W-1:0] nom,
                                          input logic [PCT_W-1:0] lo_pct,
                                          input logic [PCT_W-1:0] hi_pct);
        t_window w;
        w.lo = BOUND_W'(nom) * BOUND_W'(lo_pct);
        w.hi = BOUND_W'(nom) * BOUND_W'(hi_pct);
        return w;
    endfunction

    function automatic logic in_window(input logic [SCALED_W-1:0] scaled,
                                       input t_window w);
        return (scaled >= SCALED_W'(w.lo)) && (scaled <= SCALED_W'(w.hi));
    endfunction

endpackage

### hw/rtl/irpwd_cfg.sv
// Configuration registers and registered acceptance windows for every nominal duration.
// Depends on irpwd_pkg.
module irpwd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [irpwd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irpwd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output irpwd_pkg::t_bounds             o_bounds
);
    import irpwd_pkg::*;

    logic [TOL_W-1:0] r_tol;
    logic [EXC_W-1:0] r_excess;
    t_bounds          r_bounds;
    t_bounds          n_bounds;
    logic [PCT_W-1:0] lo_pct;
    logic [PCT_W-1:0] hi_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RESET;
            r_excess <= EXC_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TOLERANCE:   r_tol    <= i_cfg_data[TOL_W-1:0];
                REG_MARK_EXCESS: r_excess <= i_cfg_data[EXC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lo_pct = (PCT_W'(r_tol) >= PCT_FULL) ? '0 : (PCT_FULL - PCT_W'(r_tol));
        hi_pct = PCT_FULL + PCT_W'(r_tol);
        n_bounds.hdr_mark   = window_of(mark_nominal(HDR_MARK_US, r_excess), lo_pct, hi_pct);
        n_bounds.hdr_space  = window_of(space_nominal(HDR_SPACE_US, r_excess), lo_pct, hi_pct);
        n_bounds.bit_mark   = window_of(mark_nominal(BIT_MARK_US, r_excess), lo_pct, hi_pct);
        n_bounds.one_space  = window_of(space_nominal(ONE_SPACE_US, r_excess), lo_pct, hi_pct);
        n_bounds.zero_space = window_of(space_nominal(ZERO_SPACE_US, r_excess), lo_pct, hi_pct);
    end

    always_ff @(posedge i_clk) begin
        r_bounds <= n_bounds;
    end

    assign o_bounds = r_bounds;

endmodule

### hw/rtl/irpwd_decode.sv
// Input register, frame position/shift state and result register of the decoder.
// Depends on irpwd_pkg; windows come from irpwd_cfg.
module irpwd_decode #(
    parameter int CODE_BITS = irpwd_pkg::CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  irpwd_pkg::t_bounds          i_bounds,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [irpwd_pkg::DUR_W-1:0] i_duration,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_frame_valid,
    output logic [irpwd_pkg::CODE_W-1:0] o_code
);
    import irpwd_pkg::*;

    localparam int FRAME_LAST = 2 + 4 * CODE_BITS;
    localparam int PW         = $clog2(FRAME_LAST + 2);
    localparam int SW         = PW - 1;

    logic                 r_s1_valid;
    logic                 r_s1_last;
    logic [SCALED_W-1:0]  r_s1_scaled;
    logic [PW-1:0]        r_pos;
    logic [CODE_BITS-1:0] r_shift;
    logic                 r_failed;
    logic                 r_out_valid;
    logic                 r_out_frame_valid;
    logic [CODE_W-1:0]    r_out_code;

    logic                 advance;
    logic                 in_accept;
    t_match               hit;
    logic [PW-1:0]        off;
    logic [SW-1:0]        slot;
    logic [SW-1:0]        shamt;
    logic [CODE_BITS-1:0] ref_vec;
    logic                 bit_val;
    logic [PW-1:0]        n_pos;
    logic [CODE_BITS-1:0] n_shift;
    logic                 n_failed;
    logic                 frame_ok;

    assign advance    = r_s1_valid && !(r_s1_last && r_out_valid && !i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        hit.hdr_mark   = in_window(r_s1_scaled, i_bounds.hdr_mark);
        hit.hdr_space  = in_window(r_s1_scaled, i_bounds.hdr_space);
        hit.bit_mark   = in_window(r_s1_scaled, i_bounds.bit_mark);
        hit.one_space  = in_window(r_s1_scaled, i_bounds.one_space);
        hit.zero_space = in_window(r_s1_scaled, i_bounds.zero_space);
    end

    always_comb begin
        off      = r_pos - PW'(3);
        slot     = off[PW-1:1];
        shamt    = SW'(2 * CODE_BITS - 1) - slot;
        ref_vec  = r_shift >> shamt;
        bit_val  = hit.one_space;
        n_shift  = r_shift;
        n_failed = r_failed;
        if (r_pos >= PW'(1) && r_pos <= PW'(FRAME_LAST) && !r_failed) begin
            if (r_pos == PW'(1)) begin
                n_failed = !hit.hdr_mark;
            end else if (r_pos == PW'(2)) begin
                n_failed = !hit.hdr_space;
            end else if (!off[0]) begin
                n_failed = !hit.bit_mark;
            end else if (!hit.one_space && !hit.zero_space) begin
                n_failed = 1'b1;
            end else if (slot < SW'(CODE_BITS)) begin
                n_shift = (r_shift << 1) | CODE_BITS'(bit_val);
            end else begin
                n_failed = (bit_val == ref_vec[0]);
            end
        end
        n_pos    = (r_pos <= PW'(FRAME_LAST)) ? (r_pos + PW'(1)) : r_pos;
        frame_ok = !n_failed && (r_pos >= PW'(FRAME_LAST));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_last   <= i_last;
            r_s1_scaled <= SCALED_W'(i_duration) * SCALED_W'(100);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_shift  <= '0;
            r_failed <= 1'b0;
        end else if (advance) begin
            if (r_s1_last) begin
                r_pos    <= '0;
                r_shift  <= '0;
                r_failed <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_shift  <= n_shift;
                r_failed <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_last) begin
            r_out_frame_valid <= frame_ok;
            r_out_code        <= frame_ok ? CODE_W'(n_shift) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_valid = r_out_frame_valid;
    assign o_code        = r_out_code;

endmodule

### hw/rtl/ir_pulse_width_frame_decoder_core.sv
// Top level of the infrared pulse-width frame decoder: stream ports and configuration port.
// Depends on irpwd_pkg, irpwd_cfg and irpwd_decode.
//
// Feed captured mark/space durations in microseconds, one item per cycle, with tlast on
// the final duration of a frame. The first duration is the leading gap; then come a header
// mark and space, CODE_BITS data bits (mark plus long or short space, MSB first) and the
// same bits inverted. One result item follows each tlast: tuser is the frame-valid flag and
// tdata the code (zero when invalid). Throughput is one item per cycle; each result passes through
// the input register and then the result register. The input stalls only while a final
// duration waits behind a result that has not been taken.
// Configuration writes take effect for items accepted from the next cycle on.
module ir_pulse_width_frame_decoder_core #(
    parameter int CODE_BITS = irpwd_pkg::CODE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [irpwd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [15:0] duration
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [irpwd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [11:0] code, rest zero
    output logic                               m_axis_tuser,   // [0] frame_valid
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [irpwd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [irpwd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import irpwd_pkg::*;

    t_bounds            bounds;
    logic [CODE_W-1:0]  code;

    assign o_cfg_ready = 1'b1;

    irpwd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bounds    (bounds)
    );

    irpwd_decode #(
        .CODE_BITS (CODE_BITS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bounds      (bounds),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_duration    (s_axis_tdata[DUR_W-1:0]),
        .i_last        (s_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_frame_valid (m_axis_tuser),
        .o_code        (code)
    );

    assign m_axis_tdata = OUT_TDATA_W'(code);

    a_invalid_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (code == '0))
        else $error("invalid frame result carries a nonzero code");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("blocked result changed before it was taken");

endmodule
